>>> hw/rtl/icsp_pkg.sv
`default_nettype none
package icsp_pkg;

	localparam int REG_W    = 20;
	localparam int NUM_REGS = 8;
	localparam int SHIFT_W  = 33;
	localparam int ACCUM_W  = 16;
	localparam int WORD_W   = 14;

	localparam logic [3:0] MODE_ENTER     = 4'd0;
	localparam logic [3:0] MODE_EXIT      = 4'd1;
	localparam logic [3:0] MODE_LOAD_CFG  = 4'd2;
	localparam logic [3:0] MODE_LOAD      = 4'd3;
	localparam logic [3:0] MODE_READ      = 4'd4;
	localparam logic [3:0] MODE_INC       = 4'd5;
	localparam logic [3:0] MODE_RESET_ADR = 4'd6;
	localparam logic [3:0] MODE_PROG      = 4'd7;
	localparam logic [3:0] MODE_PROG_CFG  = 4'd8;
	localparam logic [3:0] MODE_ERASE     = 4'd9;

	localparam logic [2:0] REG_CLK_HIGH    = 3'd0;
	localparam logic [2:0] REG_CLK_LOW     = 3'd1;
	localparam logic [2:0] REG_GAP         = 3'd2;
	localparam logic [2:0] REG_ENTRY_SETUP = 3'd3;
	localparam logic [2:0] REG_ENTRY_HOLD  = 3'd4;
	localparam logic [2:0] REG_PROGRAM     = 3'd5;
	localparam logic [2:0] REG_PROGRAM_CFG = 3'd6;
	localparam logic [2:0] REG_ERASE       = 3'd7;

	localparam logic [SHIFT_W-1:0] ENTRY_KEY = 33'h0_4D43_4850;

	localparam logic [5:0] OP_LOAD_CFG = 6'h00;
	localparam logic [5:0] OP_LOAD     = 6'h02;
	localparam logic [5:0] OP_READ     = 6'h04;
	localparam logic [5:0] OP_INC      = 6'h06;
	localparam logic [5:0] OP_RST_ADR  = 6'h16;
	localparam logic [5:0] OP_PROG     = 6'h08;
	localparam logic [5:0] OP_ERASE    = 6'h09;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ENT_SETUP,
		PH_ENT_CLK,
		PH_ENT_HOLD,
		PH_BIT_HI,
		PH_BIT_LO,
		PH_GAP,
		PH_FINAL
	} icsp_phase_t;

	typedef enum logic [1:0] {
		SEG_OPCODE,
		SEG_PAYLOAD,
		SEG_READ,
		SEG_KEY
	} icsp_seg_t;

	typedef struct packed {
		logic mclr_n;
		logic dat_drive;
		logic dat_level;
		logic clk_drive;
		logic clk_level;
	} icsp_pins_t;

	typedef struct packed {
		logic [REG_W-1:0] clk_high_ticks;
		logic [REG_W-1:0] clk_low_ticks;
		logic [REG_W-1:0] gap_ticks;
		logic [REG_W-1:0] entry_setup_ticks;
		logic [REG_W-1:0] entry_hold_ticks;
		logic [REG_W-1:0] program_ticks;
		logic [REG_W-1:0] program_cfg_ticks;
		logic [REG_W-1:0] erase_ticks;
	} icsp_cfg_t;

	localparam icsp_cfg_t CFG_RESET = '{
		clk_high_ticks:    20'd1,
		clk_low_ticks:     20'd1,
		gap_ticks:         20'd1,
		entry_setup_ticks: 20'd1,
		entry_hold_ticks:  20'd250,
		program_ticks:     20'd2500,
		program_cfg_ticks: 20'd5000,
		erase_ticks:       20'd5000
	};

	typedef struct packed {
		logic              start_req;
		logic [3:0]        mode;
		logic [WORD_W-1:0] data_word;
		logic              dat_sample;
	} icsp_in_t;

	typedef struct packed {
		logic              clk_level;
		logic              clk_drive;
		logic              dat_level;
		logic              dat_drive;
		logic              mclr_n;
		logic              busy_res;
		logic              done_res;
		logic              read_valid;
		logic [WORD_W-1:0] read_word;
	} icsp_out_t;

	function automatic logic [5:0] opcode_of(input logic [3:0] mode);
		logic [5:0] op;
		case (mode)
			MODE_LOAD_CFG:  op = OP_LOAD_CFG;
			MODE_LOAD:      op = OP_LOAD;
			MODE_READ:      op = OP_READ;
			MODE_INC:       op = OP_INC;
			MODE_RESET_ADR: op = OP_RST_ADR;
			MODE_PROG:      op = OP_PROG;
			MODE_PROG_CFG:  op = OP_PROG;
			MODE_ERASE:     op = OP_ERASE;
			default:        op = 6'h00;
		endcase
		return op;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/icsp_lvp_command_sequencer_top.sv
`default_nettype none
// a result is registered on acceptance: into the output register, or into the skid entry if that is full
// throughput: one item per cycle while in_stall is low; the sequencer state advances once per accepted item
// a two-entry output stage (register plus skid) keeps input open while one result waits
// reset: asynchronous; sequencer idle with pin state mclr high, clock and data released,
// timing registers at their default values
module icsp_lvp_command_sequencer_top #(
	parameter int TIMER_BITS = 20
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire icsp_pkg::icsp_in_t in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output icsp_pkg::icsp_out_t     out_item,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import icsp_pkg::*;

	icsp_cfg_t        cfg_q;
	icsp_out_t        res;
	icsp_out_t        skid_item_q;
	logic             skid_valid_q;
	logic             acc;
	logic             take;
	logic [2:0]       reg_idx;
	logic [REG_W-1:0] rd_val;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[4:2];
	assign in_stall = skid_valid_q;
	assign acc      = in_valid && !skid_valid_q;
	assign take     = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_CLK_HIGH:    cfg_q.clk_high_ticks    <= pwdata[REG_W-1:0];
				REG_CLK_LOW:     cfg_q.clk_low_ticks     <= pwdata[REG_W-1:0];
				REG_GAP:         cfg_q.gap_ticks         <= pwdata[REG_W-1:0];
				REG_ENTRY_SETUP: cfg_q.entry_setup_ticks <= pwdata[REG_W-1:0];
				REG_ENTRY_HOLD:  cfg_q.entry_hold_ticks  <= pwdata[REG_W-1:0];
				REG_PROGRAM:     cfg_q.program_ticks     <= pwdata[REG_W-1:0];
				REG_PROGRAM_CFG: cfg_q.program_cfg_ticks <= pwdata[REG_W-1:0];
				default:         cfg_q.erase_ticks       <= pwdata[REG_W-1:0];
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CLK_HIGH:    rd_val = cfg_q.clk_high_ticks;
			REG_CLK_LOW:     rd_val = cfg_q.clk_low_ticks;
			REG_GAP:         rd_val = cfg_q.gap_ticks;
			REG_ENTRY_SETUP: rd_val = cfg_q.entry_setup_ticks;
			REG_ENTRY_HOLD:  rd_val = cfg_q.entry_hold_ticks;
			REG_PROGRAM:     rd_val = cfg_q.program_ticks;
			REG_PROGRAM_CFG: rd_val = cfg_q.program_cfg_ticks;
			default:         rd_val = cfg_q.erase_ticks;
		endcase
		prdata = {{(32 - REG_W){1'b0}}, rd_val};
	end

	icsp_seq_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (acc),
		.item   (in_item),
		.cfg    (cfg_q),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid <= acc;
			end
		end else if (acc) begin
			if (out_valid)
				skid_valid_q <= 1'b1;
			else
				out_valid <= 1'b1;
		end
	end

	// item storage
	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q)
				out_item <= skid_item_q;
			else if (acc)
				out_item <= res;
		end else if (acc) begin
			if (out_valid)
				skid_item_q <= res;
			else
				out_item <= res;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/icsp_seq_core.sv
`default_nettype none
module icsp_seq_core #(
	parameter int TIMER_BITS = 20
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire icsp_pkg::icsp_in_t  item,
	input  wire icsp_pkg::icsp_cfg_t cfg,
	output icsp_pkg::icsp_out_t    result
);
	import icsp_pkg::*;

	localparam int WW = (TIMER_BITS > REG_W) ? TIMER_BITS : REG_W;

	icsp_phase_t             phase_q, phase_n;
	icsp_seg_t               seg_q, seg_n;
	logic [3:0]              mode_q, mode_n;
	logic [5:0]              cnt_q, cnt_n, cnt_dec;
	logic [SHIFT_W-1:0]      shift_q, shift_n;
	logic [TIMER_BITS-1:0]   timer_q, timer_n;
	logic [ACCUM_W-1:0]      accum_q, accum_n;
	icsp_pins_t              pins_q, pins_n;
	logic                    finish;
	logic                    do_bit;
	logic [WORD_W:0]         payload;

	// wait of t ticks loads t-1 (0 for t=0), saturated to the timer width
	function automatic logic [TIMER_BITS-1:0] load_wait(input logic [REG_W-1:0] ticks);
		logic [REG_W-1:0] t;
		logic [WW-1:0]    ext;
		logic [TIMER_BITS-1:0] r;
		t   = (ticks == '0) ? '0 : ticks - 1'b1;
		ext = WW'(t);
		if (ext > WW'({TIMER_BITS{1'b1}}))
			r = '1;
		else
			r = ext[TIMER_BITS-1:0];
		return r;
	endfunction

	always_comb begin
		phase_n = phase_q;
		seg_n   = seg_q;
		mode_n  = mode_q;
		cnt_n   = cnt_q;
		shift_n = shift_q;
		timer_n = timer_q;
		accum_n = accum_q;
		pins_n  = pins_q;
		finish  = 1'b0;
		do_bit  = 1'b0;
		cnt_dec = (cnt_q != '0) ? cnt_q - 1'b1 : '0;
		payload = (item.mode == MODE_LOAD) ? {item.data_word, 1'b0} : '0;
		if (step) begin
			if (phase_q == PH_IDLE) begin
				if (item.start_req && item.mode <= MODE_ERASE) begin
					mode_n = item.mode;
					case (item.mode)
						MODE_ENTER: begin
							pins_n  = '{mclr_n: 1'b1, dat_drive: 1'b1, default: 1'b0};
							timer_n = load_wait(cfg.entry_setup_ticks);
							phase_n = PH_ENT_SETUP;
						end
						MODE_EXIT: begin
							pins_n  = '{mclr_n: 1'b1, dat_drive: 1'b1, default: 1'b0};
							timer_n = '0;
							phase_n = PH_FINAL;
						end
						default: begin
							shift_n = {12'b0, payload, opcode_of(item.mode)};
							seg_n   = SEG_OPCODE;
							cnt_n   = 6'd6;
							do_bit  = 1'b1;
						end
					endcase
				end
			end else if (timer_q != '0 && phase_q != PH_ENT_CLK) begin
				timer_n = timer_q - 1'b1;
			end else begin
				case (phase_q)
					PH_ENT_SETUP: begin
						pins_n  = '{mclr_n: 1'b1, dat_drive: 1'b1, clk_drive: 1'b1,
							default: 1'b0};
						phase_n = PH_ENT_CLK;
					end
					PH_ENT_CLK: begin
						pins_n  = '{dat_drive: 1'b1, clk_drive: 1'b1, default: 1'b0};
						timer_n = load_wait(cfg.entry_hold_ticks);
						phase_n = PH_ENT_HOLD;
					end
					PH_ENT_HOLD: begin
						shift_n = ENTRY_KEY;
						seg_n   = SEG_KEY;
						cnt_n   = 6'd33;
						do_bit  = 1'b1;
					end
					PH_BIT_HI: begin
						pins_n.clk_level = 1'b0;
						timer_n = load_wait(cfg.clk_low_ticks);
						phase_n = PH_BIT_LO;
					end
					PH_BIT_LO: begin
						if (seg_q == SEG_READ)
							accum_n = {item.dat_sample, accum_q[ACCUM_W-1:1]};
						cnt_n = cnt_dec;
						if (cnt_dec != '0) begin
							do_bit = 1'b1;
						end else begin
							case (seg_q)
								SEG_KEY: begin
									finish = 1'b1;
								end
								SEG_OPCODE: begin
									phase_n = PH_FINAL;
									case (mode_q)
										MODE_PROG:     timer_n = load_wait(cfg.program_ticks);
										MODE_PROG_CFG: timer_n = load_wait(cfg.program_cfg_ticks);
										MODE_ERASE:    timer_n = load_wait(cfg.erase_ticks);
										MODE_INC, MODE_RESET_ADR: begin
											timer_n = load_wait(cfg.gap_ticks);
										end
										default: begin
											timer_n = load_wait(cfg.gap_ticks);
											phase_n = PH_GAP;
										end
									endcase
								end
								default: begin
									if (seg_q == SEG_READ)
										pins_n = '{clk_drive: 1'b1, dat_drive: 1'b1,
											default: 1'b0};
									timer_n = load_wait(cfg.gap_ticks);
									phase_n = PH_FINAL;
								end
							endcase
						end
					end
					PH_GAP: begin
						if (mode_q == MODE_READ) begin
							seg_n   = SEG_READ;
							accum_n = '0;
						end else begin
							seg_n   = SEG_PAYLOAD;
						end
						cnt_n  = 6'd16;
						do_bit = 1'b1;
					end
					default: begin
						finish = 1'b1;
					end
				endcase
			end
			// start of one serial bit: data set up (released in a read segment), clock high
			if (do_bit) begin
				pins_n.clk_level = 1'b1;
				pins_n.clk_drive = 1'b1;
				pins_n.dat_drive = (seg_n != SEG_READ);
				pins_n.dat_level = (seg_n != SEG_READ) && shift_n[0];
				pins_n.mclr_n    = 1'b0;
				shift_n = shift_n >> 1;
				timer_n = load_wait(cfg.clk_high_ticks);
				phase_n = PH_BIT_HI;
			end
			if (finish)
				phase_n = PH_IDLE;
		end
	end

	always_comb begin
		result.clk_level  = pins_n.clk_level;
		result.clk_drive  = pins_n.clk_drive;
		result.dat_level  = pins_n.dat_level;
		result.dat_drive  = pins_n.dat_drive;
		result.mclr_n     = pins_n.mclr_n;
		result.busy_res   = (phase_n != PH_IDLE);
		result.done_res   = finish;
		result.read_valid = finish && (mode_n == MODE_READ);
		result.read_word  = (finish && mode_n == MODE_READ) ? accum_n[WORD_W:1] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			seg_q   <= SEG_OPCODE;
			mode_q  <= '0;
			cnt_q   <= '0;
			shift_q <= '0;
			timer_q <= '0;
			accum_q <= '0;
			pins_q  <= '{mclr_n: 1'b1, default: 1'b0};
		end else begin
			phase_q <= phase_n;
			seg_q   <= seg_n;
			mode_q  <= mode_n;
			cnt_q   <= cnt_n;
			shift_q <= shift_n;
			timer_q <= timer_n;
			accum_q <= accum_n;
			pins_q  <= pins_n;
		end
	end

endmodule
`default_nettype wire
